// ----- rtl/deque_with_membership_search_core_assert.svh -----
// Assertion macros shared by the deque checker.
`ifndef DEQUE_WITH_MEMBERSHIP_SEARCH_CORE_ASSERT_SVH
`define DEQUE_WITH_MEMBERSHIP_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, sampled at the rising clock, off during reset
`define DWMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled at the rising clock, off during reset
`define DWMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dwms_pkg.sv -----
// Shared types and constants of the deque with membership search.
package dwms_pkg;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_POP_FRONT  = 2'd1,
        FUNC_POP_BACK   = 2'd2,
        FUNC_SEARCH     = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0]        t_count;

endpackage

// ----- rtl/dwms_if.sv -----
// Valid/ready channel interfaces for commands and results.
interface dwms_cmd_if;
    import dwms_pkg::*;

    logic   valid;
    logic   ready;
    t_func  func;
    t_value value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface dwms_rsp_if;
    import dwms_pkg::*;

    logic    valid;
    logic    ready;
    logic    found;
    t_status status;
    t_count  count;

    modport source (output valid, output found, output status, output count, input ready);
    modport sink   (input valid, input found, input status, input count, output ready);
endinterface

// ----- rtl/dwms_ram.sv -----
// Element store: one write port, one read port, registered read data.
module dwms_ram #(
    parameter int DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  dwms_pkg::t_value       i_wdata,
    input  logic                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output dwms_pkg::t_value       o_rdata
);
    import dwms_pkg::*;

    t_value r_mem [DEPTH];
    t_value r_rdata;

    // Write one element
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one element into the registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/deque_with_membership_search_core.sv -----
// Push and pop: result is loaded from S_EXEC once the output slot is free; the next item is accepted after that.
// Search: reads the ring store one element per cycle through its single read port,
// so the walk covers every element held (at most DEPTH) before the result is loaded in S_EXEC
// once the output slot is free; the next item is accepted after that.
// Output register keeps a finished result while the next item is accepted.
// Synchronous active-low reset empties the queue (head 0, count 0); store is not cleared.
module deque_with_membership_search_core #(
    parameter int DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dwms_cmd_if.sink   i_cmd,
    dwms_rsp_if.source o_rsp
);
    import dwms_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EXEC
    } t_state;

    t_state          r_state,      n_state;
    logic [AW-1:0]   r_head,       n_head;
    logic [CW-1:0]   r_cnt,        n_cnt;
    logic [AW-1:0]   r_ptr,        n_ptr;
    logic [CW-1:0]   r_left,       n_left;
    logic            r_rd_pend,    n_rd_pend;
    logic            r_found,      n_found;
    t_func           r_func,       n_func;
    t_value          r_value,      n_value;
    logic            r_rsp_valid,  n_rsp_valid;
    logic            r_rsp_found,  n_rsp_found;
    t_status         r_rsp_status, n_rsp_status;
    t_count          r_rsp_count,  n_rsp_count;

    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   head_dec;
    t_value          ram_rdata;
    logic            out_free;
    logic            is_full;
    logic            is_empty;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        logic [AW-1:0] nxt;
        nxt = (idx == AW'(DEPTH - 1)) ? '0 : AW'(idx + AW'(1));
        return nxt;
    endfunction

    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : AW'(r_head - AW'(1));
    assign out_free = !r_rsp_valid || o_rsp.ready;
    assign is_full  = (r_cnt == CW'(DEPTH));
    assign is_empty = (r_cnt == '0);

    dwms_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (head_dec),
        .i_wdata (r_value),
        .i_re    (ram_re),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // Sequence accept, store walk and result hand-off
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_cnt        = r_cnt;
        n_ptr        = r_ptr;
        n_left       = r_left;
        n_rd_pend    = r_rd_pend;
        n_found      = r_found;
        n_func       = r_func;
        n_value      = r_value;
        n_rsp_valid  = r_rsp_valid;
        n_rsp_found  = r_rsp_found;
        n_rsp_status = r_rsp_status;
        n_rsp_count  = r_rsp_count;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        // Drop a result once taken
        if (r_rsp_valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_func    = i_cmd.func;
                    n_value   = i_cmd.value;
                    n_ptr     = r_head;
                    n_left    = r_cnt;
                    n_found   = 1'b0;
                    n_rd_pend = 1'b0;
                    n_state   = (i_cmd.func == FUNC_SEARCH) ? S_WALK : S_EXEC;
                end
            end
            S_WALK: begin
                // Issue one read per cycle, head to tail
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    n_ptr     = wrap_inc(r_ptr);
                    n_left    = CW'(r_left - CW'(1));
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                end
                // Compare the element read last cycle
                if (r_rd_pend && (ram_rdata == r_value)) begin
                    n_found = 1'b1;
                end
                if ((r_left == '0) && !r_rd_pend) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // Commit and load the result when the output slot is free
                if (out_free) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_found  = 1'b0;
                    n_rsp_status = ST_DONE;
                    n_state      = S_IDLE;
                    case (r_func)
                        FUNC_PUSH_FRONT: begin
                            if (is_full) begin
                                n_rsp_status = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                n_head = head_dec;
                                n_cnt  = CW'(r_cnt + CW'(1));
                            end
                        end
                        FUNC_POP_FRONT: begin
                            if (is_empty) begin
                                n_rsp_status = ST_EMPTY;
                            end else begin
                                n_head = wrap_inc(r_head);
                                n_cnt  = CW'(r_cnt - CW'(1));
                            end
                        end
                        FUNC_POP_BACK: begin
                            if (is_empty) begin
                                n_rsp_status = ST_EMPTY;
                            end else begin
                                n_cnt = CW'(r_cnt - CW'(1));
                            end
                        end
                        FUNC_SEARCH: begin
                            n_rsp_found = r_found;
                        end
                        default: begin
                            n_rsp_status = ST_DONE;
                        end
                    endcase
                    n_rsp_count = COUNT_W'(n_cnt);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_left      <= '0;
            r_rd_pend   <= 1'b0;
            r_found     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_ptr       <= n_ptr;
            r_left      <= n_left;
            r_rd_pend   <= n_rd_pend;
            r_found     <= n_found;
            r_rsp_valid <= n_rsp_valid;
        end
        r_func       <= n_func;
        r_value      <= n_value;
        r_rsp_found  <= n_rsp_found;
        r_rsp_status <= n_rsp_status;
        r_rsp_count  <= n_rsp_count;
    end

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_rsp_valid;
    assign o_rsp.found  = r_rsp_found;
    assign o_rsp.status = r_rsp_status;
    assign o_rsp.count  = r_rsp_count;

endmodule

// ----- rtl/dwms_checker.sv -----
// Port-level checker for the deque core, bound to the core module.
`include "deque_with_membership_search_core_assert.svh"

module dwms_checker #(
    parameter int DEPTH = 64
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cmd_valid,
    input logic                        i_cmd_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic                        i_rsp_found,
    input logic [dwms_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [dwms_pkg::COUNT_W-1:0]  i_rsp_count
);
    import dwms_pkg::*;

    // Result stays offered until taken
    `DWMS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "result dropped while stalled")

    // One item at a time: no accept right after an accept
    `DWMS_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready, !i_cmd_ready, "second item accepted while busy")

    // A refused push reports a full queue
    `DWMS_ASSERT_NOW(a_full_count, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status == ST_FULL), i_rsp_count == COUNT_W'(DEPTH), "full status with wrong count")

    // An ignored pop reports an empty queue, and a hit is never an error
    `DWMS_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status == ST_EMPTY), (i_rsp_count == '0) && !i_rsp_found, "empty status with elements or hit")

endmodule

bind deque_with_membership_search_core dwms_checker #(
    .DEPTH(DEPTH)
) u_dwms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_found  (o_rsp.found),
    .i_rsp_status (o_rsp.status),
    .i_rsp_count  (o_rsp.count)
);
